// ----- rtl/nps_pkg.sv -----
// nps_pkg: shared types and constants of the nearest point search block
// word layouts, command and register codes, controller states, control structs
// no dependencies
package nps_pkg;

    // field widths
    localparam int NPS_MAX_POINTS = 1024;
    localparam int COORD_BITS     = 24;
    localparam int IDX_W          = 11;
    localparam int DIST_W         = 52;
    localparam int DIFF_W         = COORD_BITS + 1;
    localparam int SQ_W           = 2 * COORD_BITS;
    localparam int SUM_W          = SQ_W + 2;
    localparam int PT_W           = 3 * COORD_BITS;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 11;

    // input word commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THREE_DIM  = 1'd1;

    typedef struct packed {
        logic                         command;
        logic [IDX_W-1:0]             point_index;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]  nearest_index;
        logic              found;
        logic [DIST_W-1:0] min_distance_sq;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic issue;
        logic load_result;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_is_query;
        logic scan_empty;
        logic last_issue;
        logic pipe_idle;
    } dp_status_t;

endpackage

// ----- rtl/nps_ram.sv -----
// nps_ram: generic single port RAM with registered read
// one write or one read address per cycle
// no dependencies
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/nps_ctrl.sv -----
// nps_ctrl: controller state machine of the nearest point search block
// runs handshakes, scan sequencing and result hand-off
// depends on nps_pkg
module nps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  nps_pkg::dp_status_t status,
    output nps_pkg::ctrl_cmd_t  cmd
);

    import nps_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // result slot free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.item_is_query && !status.scan_empty)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (status.last_issue)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (status.pipe_idle)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready        = 1'b0;
        cmd.load_item   = 1'b0;
        cmd.issue       = 1'b0;
        cmd.load_result = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_FINISH:
            begin
                cmd.load_result = slot_free;
                if (slot_free)
                    out_valid_next = 1'b1;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/nps_datapath.sv -----
// nps_datapath: point store, distance pipeline and running minimum
// config registers, scan counter and result word register live here
// depends on nps_pkg and nps_ram
module nps_datapath #(
    parameter int MAX_POINTS = nps_pkg::NPS_MAX_POINTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nps_pkg::in_t                        in_data,
    input  logic                                cfg_valid,
    input  logic [nps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  nps_pkg::ctrl_cmd_t                  cmd,
    output nps_pkg::dp_status_t                 status,
    output nps_pkg::out_t                       out_data
);

    import nps_pkg::*;

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int WIDE_W = (IDX_W > CNT_W + 1) ? IDX_W : CNT_W + 1;

    // configuration
    logic [CFG_DATA_W-1:0] num_points_reg;
    logic                  three_dim_reg;

    // query point and scan control
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic [CNT_W-1:0]             scan_len_reg;
    logic [CNT_W-1:0]             scan_len_next;
    logic [CNT_W-1:0]             scan_cnt_reg;
    logic [WIDE_W-1:0]            idx_wide;
    logic [WIDE_W-1:0]            wr_addr_wide;
    logic                         idx_ok;

    // store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [PT_W-1:0]   ram_wdata;
    logic [PT_W-1:0]   ram_rdata;

    // pipeline
    logic                         rd_valid_reg;
    logic [IDX_W-1:0]             rd_idx_reg;
    logic signed [COORD_BITS-1:0] st_x, st_y, st_z;
    logic                         diff_valid_reg;
    logic [IDX_W-1:0]             diff_idx_reg;
    logic signed [DIFF_W-1:0]     diff_x_reg, diff_y_reg, diff_z_reg;
    logic signed [2*DIFF_W-1:0]   prod_x, prod_y, prod_z;
    logic                         sq_valid_reg;
    logic [IDX_W-1:0]             sq_idx_reg;
    logic [SQ_W-1:0]              sq_x_reg, sq_y_reg, sq_z_reg;
    logic                         sum_valid_reg;
    logic [IDX_W-1:0]             sum_idx_reg;
    logic [SUM_W-1:0]             sum_reg;

    // running minimum and result word
    logic             have_reg;
    logic [SUM_W-1:0] best_reg;
    logic [IDX_W-1:0] best_idx_reg;
    out_t             out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= '0;
            three_dim_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NUM_POINTS: num_points_reg <= cfg_data;
                REG_THREE_DIM:  three_dim_reg  <= cfg_data[0];
            endcase
        end
    end

    // scan length clamped to the store depth
    always_comb
    begin
        if (WIDE_W'(num_points_reg) > WIDE_W'(MAX_POINTS))
            scan_len_next = CNT_W'(MAX_POINTS);
        else
            scan_len_next = CNT_W'(num_points_reg);
    end

    // write slot check and address
    assign idx_ok = (in_data.point_index != '0) &&
                    (WIDE_W'(in_data.point_index) <= WIDE_W'(MAX_POINTS));
    assign wr_addr_wide = WIDE_W'(in_data.point_index) - WIDE_W'(1);

    // store access: write on an accepted write word, read while scanning
    assign ram_we    = cmd.load_item && (in_data.command == CMD_WRITE) && idx_ok;
    assign ram_addr  = cmd.issue ? ADDR_W'(scan_cnt_reg) : wr_addr_wide[ADDR_W-1:0];
    assign ram_wdata = {in_data.coord_z, in_data.coord_y, in_data.coord_x};

    nps_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // query point and scan length capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            qx_reg       <= in_data.coord_x;
            qy_reg       <= in_data.coord_y;
            qz_reg       <= in_data.coord_z;
            scan_len_reg <= scan_len_next;
        end
    end

    // scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_cnt_reg <= '0;
        else if (cmd.load_item)
            scan_cnt_reg <= '0;
        else if (cmd.issue)
            scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
    end

    // 1-based index of the slot being read
    assign idx_wide = WIDE_W'(scan_cnt_reg) + WIDE_W'(1);

    assign st_x = ram_rdata[COORD_BITS-1:0];
    assign st_y = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign st_z = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];

    // squares of the differences
    assign prod_x = diff_x_reg * diff_x_reg;
    assign prod_y = diff_y_reg * diff_y_reg;
    assign prod_z = diff_z_reg * diff_z_reg;

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            diff_valid_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.issue;
            diff_valid_reg <= rd_valid_reg;
            sq_valid_reg   <= diff_valid_reg;
            sum_valid_reg  <= sq_valid_reg;
        end
    end

    // pipeline data: read, difference, square, sum
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= idx_wide[IDX_W-1:0];
        diff_idx_reg <= rd_idx_reg;
        diff_x_reg   <= DIFF_W'(st_x) - DIFF_W'(qx_reg);
        diff_y_reg   <= DIFF_W'(st_y) - DIFF_W'(qy_reg);
        diff_z_reg   <= DIFF_W'(st_z) - DIFF_W'(qz_reg);
        sq_idx_reg   <= diff_idx_reg;
        sq_x_reg     <= prod_x[SQ_W-1:0];
        sq_y_reg     <= prod_y[SQ_W-1:0];
        sq_z_reg     <= prod_z[SQ_W-1:0];
        sum_idx_reg  <= sq_idx_reg;
        sum_reg      <= SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg) +
                        (three_dim_reg ? SUM_W'(sq_z_reg) : '0);
    end

    // running minimum, first strictly smaller distance wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            have_reg <= 1'b0;
        else if (cmd.load_item)
            have_reg <= 1'b0;
        else if (sum_valid_reg)
            have_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid_reg && (!have_reg || (sum_reg < best_reg)))
        begin
            best_reg     <= sum_reg;
            best_idx_reg <= sum_idx_reg;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_data_reg.nearest_index   <= have_reg ? best_idx_reg : '0;
            out_data_reg.found           <= have_reg;
            out_data_reg.min_distance_sq <= have_reg ? DIST_W'(best_reg) : '0;
        end
    end

    assign out_data = out_data_reg;

    // status to controller
    assign status.item_is_query = (in_data.command == CMD_QUERY);
    assign status.scan_empty    = (num_points_reg == '0);
    assign status.last_issue    = (scan_cnt_reg == scan_len_reg - CNT_W'(1));
    assign status.pipe_idle     = !(rd_valid_reg || diff_valid_reg ||
                                    sq_valid_reg || sum_valid_reg);

endmodule

// ----- rtl/nearest_point_search.sv -----
// nearest_point_search: top level of the brute-force nearest point search
// joins the controller nps_ctrl and the datapath nps_datapath
// depends on nps_pkg, nps_ctrl, nps_datapath, nps_ram
//
// Usage: an input word either writes a point (x, y, z in signed Q12.12) into
// 1-based slot point_index, or queries the point nearest to (x, y, z) over
// slots 1..num_points, clamped to MAX_POINTS. Every input word yields exactly one
// output word; for a write, and for a query with num_points zero, it is all zeros.
// Configuration: register 0 is num_points, register 1 is three_dim (1 uses
// x, y and z, 0 uses x and y). cfg_ready is always high; write only while idle.
// Sequence: a write or an empty query goes from IDLE to FINISH, where its
// output word is registered. A query over n points reads one slot a cycle
// from the single port point store in SCAN, waits in DRAIN until the
// distance pipeline is empty and registers its word in FINISH.
// A new word may be accepted while the previous output word still waits.
// If the receiver stalls, the result is held in the output register until
// out_ready; the block takes one more word, then accepts nothing meanwhile.
// Reset: num_points clears to 0 and three_dim sets to 1; the point store is
// not cleared and slots must be written before a query scans them.
module nearest_point_search #(
    parameter int MAX_POINTS = nps_pkg::NPS_MAX_POINTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  nps_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output nps_pkg::out_t                  out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0] cfg_data
);

    import nps_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // configuration writes always taken
    assign cfg_ready = 1'b1;

    nps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    nps_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// ----- dv/nearest_point_search_tb.sv -----
// nearest_point_search_tb: self-checking testbench of the nearest point search block
// predicts every output word with its own point table and compares field by field
// depends on nps_pkg and the nearest_point_search rtl
`timescale 1ns / 100ps

module nearest_point_search_tb;

    import nps_pkg::*;

    localparam int STALL_LIMIT = 8000;
    localparam int RANDOM_ITEMS = 550;
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // point table copy, settings copy and queue of answers still due
    class search_tracker;
        logic signed [COORD_BITS-1:0] slot_x [NPS_MAX_POINTS];
        logic signed [COORD_BITS-1:0] slot_y [NPS_MAX_POINTS];
        logic signed [COORD_BITS-1:0] slot_z [NPS_MAX_POINTS];
        logic [CFG_DATA_W-1:0] scan_count;
        bit use_z;
        out_t answers_due [$];
        int errors;

        function new();
            scan_count = '0;
            use_z = 1'b1;
            errors = 0;
            foreach (slot_x[i])
            begin
                slot_x[i] = '0;
                slot_y[i] = '0;
                slot_z[i] = '0;
            end
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_NUM_POINTS)
                scan_count = val;
            else if (idx == REG_THREE_DIM)
                use_z = val[0];
        endfunction

        static function logic [63:0] sq_gap(logic signed [COORD_BITS-1:0] a,
                                            logic signed [COORD_BITS-1:0] b);
            longint d;
            d = longint'(a) - longint'(b);
            return d * d;
        endfunction

        // store a point or search the table for the nearest one
        function void note_word(in_t w);
            out_t ans;
            int span;
            logic [63:0] dist_sq;
            logic [63:0] best;
            ans = '0;
            best = '0;
            if (w.command == CMD_WRITE)
            begin
                if (w.point_index >= 1 && w.point_index <= NPS_MAX_POINTS)
                begin
                    slot_x[w.point_index - 1] = w.coord_x;
                    slot_y[w.point_index - 1] = w.coord_y;
                    slot_z[w.point_index - 1] = w.coord_z;
                end
            end
            else
            begin
                span = (scan_count > NPS_MAX_POINTS) ? NPS_MAX_POINTS : int'(scan_count);
                for (int i = 0; i < span; i++)
                begin
                    dist_sq = sq_gap(slot_x[i], w.coord_x) + sq_gap(slot_y[i], w.coord_y);
                    if (use_z)
                        dist_sq += sq_gap(slot_z[i], w.coord_z);
                    // strictly smaller only, so ties keep the lowest slot
                    if (i == 0 || dist_sq < best)
                    begin
                        best = dist_sq;
                        ans.nearest_index = IDX_W'(i + 1);
                    end
                end
                if (span > 0)
                begin
                    ans.found = 1'b1;
                    ans.min_distance_sq = best[DIST_W-1:0];
                end
            end
            answers_due.push_back(ans);
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        endtask

        task check_answer(out_t got);
            out_t want;
            if (answers_due.size() == 0)
            begin
                report_mismatch("unexpected output word", '0, got);
                return;
            end
            want = answers_due.pop_front();
            if (got.nearest_index !== want.nearest_index)
                report_mismatch("nearest_index", want.nearest_index, got.nearest_index);
            if (got.found !== want.found)
                report_mismatch("found", want.found, got.found);
            if (got.min_distance_sq !== want.min_distance_sq)
                report_mismatch("min_distance_sq", want.min_distance_sq, got.min_distance_sq);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    search_tracker score = new();

    // slots written so far, and the length of the written run from slot 1
    bit slot_written [1:NPS_MAX_POINTS];
    int filled_upto = 0;
    bit batch_open = 1'b0;

    int send_left = 0;
    bit send_quiet = 1'b0;
    int recv_left = 0;
    bit recv_quiet = 1'b0;

    nearest_point_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle gap per word, with stretches of back-to-back traffic
    function automatic int draw_gap(ref int stretch_left, ref bit no_idle);
        if (stretch_left == 0)
        begin
            stretch_left = $urandom_range(40, 10);
            no_idle = ($urandom_range(3) == 0);
        end
        stretch_left--;
        return no_idle ? 0 : int'($urandom_range(6));
    endfunction

    function automatic logic signed [COORD_BITS-1:0] random_coord();
        case ($urandom_range(7))
            0: return C_MIN;
            1: return C_MAX;
            2: return COORD_BITS'(int'($urandom_range(8192)) - 4096);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] near_coord(logic signed [COORD_BITS-1:0] base);
        return COORD_BITS'(int'(base) + int'($urandom_range(64)) - 32);
    endfunction

    function automatic in_t write_word(int idx, logic signed [COORD_BITS-1:0] x,
                                       logic signed [COORD_BITS-1:0] y,
                                       logic signed [COORD_BITS-1:0] z);
        in_t w;
        w.command = CMD_WRITE;
        w.point_index = IDX_W'(idx);
        w.coord_x = x;
        w.coord_y = y;
        w.coord_z = z;
        return w;
    endfunction

    function automatic in_t query_word(logic signed [COORD_BITS-1:0] x,
                                       logic signed [COORD_BITS-1:0] y,
                                       logic signed [COORD_BITS-1:0] z);
        in_t w;
        w.command = CMD_QUERY;
        w.point_index = IDX_W'($urandom);
        w.coord_x = x;
        w.coord_y = y;
        w.coord_z = z;
        return w;
    endfunction

    // offer one word, hold it until taken
    task automatic send_word(in_t w);
        int gap;
        gap = draw_gap(send_left, send_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
        score.note_word(w);
    endtask

    task automatic send_write(int idx, logic signed [COORD_BITS-1:0] x,
                              logic signed [COORD_BITS-1:0] y,
                              logic signed [COORD_BITS-1:0] z);
        if (idx >= 1 && idx <= NPS_MAX_POINTS)
            slot_written[idx] = 1'b1;
        while (filled_upto < NPS_MAX_POINTS && slot_written[filled_upto + 1])
            filled_upto++;
        send_word(write_word(idx, x, y, z));
    endtask

    // stop offering and wait for every answer still due
    task automatic finish_batch();
        in_valid <= 1'b0;
        batch_open = 1'b0;
        while (score.answers_due.size() != 0)
            @(posedge clk);
    endtask

    // write both registers back to back, block idle
    task automatic apply_settings(int n, bit td);
        cfg_valid <= 1'b1;
        cfg_index <= REG_NUM_POINTS;
        cfg_data <= CFG_DATA_W'(n);
        do @(posedge clk); while (!cfg_ready);
        score.note_register(REG_NUM_POINTS, CFG_DATA_W'(n));
        cfg_index <= REG_THREE_DIM;
        cfg_data <= CFG_DATA_W'(td);
        do @(posedge clk); while (!cfg_ready);
        score.note_register(REG_THREE_DIM, CFG_DATA_W'(td));
        cfg_valid <= 1'b0;
        batch_open = 1'b1;
    endtask

    // receiver: random stalls, plus long hold-offs while words keep coming
    initial
    begin : receiver
        int gap;
        int received;
        int holds_done;
        received = 0;
        holds_done = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(recv_left, recv_quiet);
            if (holds_done < 2 && batch_open && received >= 60 + 250 * holds_done)
            begin
                gap = 300;
                holds_done++;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            score.check_answer(out_data);
            received++;
        end
    end

    // watchdog on cycles with no handshake on any channel
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        int lim;
        int idx;
        int k;
        int sub;
        int phase_len;
        int random_sent;
        logic signed [COORD_BITS-1:0] qx;
        logic signed [COORD_BITS-1:0] qy;
        logic signed [COORD_BITS-1:0] qz;

        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty table scan, then writes outside the table
        send_word(query_word(C_MAX, C_MIN, C_MAX));
        send_write(0, C_MAX, C_MAX, C_MAX);
        send_write(2047, C_MIN, C_MIN, C_MIN);

        // corner points, with slots 3 and 4 equal for the tie rule
        send_write(1, C_MIN, C_MIN, C_MIN);
        send_write(2, C_MAX, C_MAX, C_MAX);
        send_write(3, '0, '0, '0);
        send_write(4, '0, '0, '0);
        send_write(5, 24'sd4096, -24'sd4096, 24'sd1);
        send_write(6, -24'sd1, -24'sd1, -24'sd1);
        send_write(7, '0, '0, C_MAX);
        send_write(8, 24'sd100, 24'sd200, -24'sd300);
        send_write(NPS_MAX_POINTS, 24'sd1, 24'sd2, 24'sd3);
        finish_batch();

        apply_settings(8, 1'b1);
        send_word(query_word(C_MAX, C_MAX, C_MAX));
        send_word(query_word(C_MIN, C_MIN, C_MIN));
        send_word(query_word('0, '0, '0));
        send_word(query_word('0, '0, C_MAX));
        send_word(query_word(C_MIN, C_MAX, '0));
        finish_batch();

        // 2d: z is ignored, so slots 3, 4 and 7 tie
        apply_settings(8, 1'b0);
        send_word(query_word('0, '0, C_MAX));
        send_word(query_word(C_MAX, C_MIN, 24'sd5));
        send_word(query_word(24'sd1, 24'sd1, 24'sd1));
        finish_batch();

        // single slot, widest possible distance
        apply_settings(1, 1'b1);
        send_word(query_word(C_MAX, C_MAX, C_MAX));
        send_write(1, C_MAX, C_MIN, '0);
        send_word(query_word(C_MIN, C_MAX, C_MIN));
        finish_batch();

        // random phases, each with its own settings
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            lim = (filled_upto < 24) ? filled_upto : 24;
            case ($urandom_range(9))
                0: n = 0;
                1: n = filled_upto;
                default: n = $urandom_range(lim, 1);
            endcase
            apply_settings(n, 1'($urandom_range(1)));
            phase_len = $urandom_range(50, 15);
            repeat (phase_len)
            begin
                if ($urandom_range(99) < 45)
                begin
                    sub = $urandom_range(9);
                    if (sub == 0)
                        idx = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(2047, 1025));
                    else if (sub < 4 && filled_upto < NPS_MAX_POINTS)
                        idx = filled_upto + 1;
                    else if (sub == 4)
                        idx = NPS_MAX_POINTS;
                    else
                        idx = $urandom_range(filled_upto + 8, 1);
                    if (n > 0 && $urandom_range(3) == 0)
                    begin
                        // duplicate of a scanned point, to make ties
                        k = $urandom_range(n, 1);
                        send_write(idx, score.slot_x[k-1], score.slot_y[k-1], score.slot_z[k-1]);
                    end
                    else
                        send_write(idx, random_coord(), random_coord(), random_coord());
                end
                else
                begin
                    if (n > 0 && $urandom_range(1) == 1)
                    begin
                        k = $urandom_range(n, 1);
                        qx = near_coord(score.slot_x[k-1]);
                        qy = near_coord(score.slot_y[k-1]);
                        qz = near_coord(score.slot_z[k-1]);
                    end
                    else
                    begin
                        qx = random_coord();
                        qy = random_coord();
                        qz = random_coord();
                    end
                    send_word(query_word(qx, qy, qz));
                end
            end
            random_sent += phase_len;
            finish_batch();
        end

        // let any stray word show up before the verdict
        repeat (20) @(posedge clk);
        if (score.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
